// ===== rtl/acws_pkg.sv =====
// Shared types, codes and helpers of the adaptive cache way shifter.
package acws_pkg;

    localparam int DEF_CORES     = 4;
    localparam int DEF_ORIGIN_L1 = 8;
    localparam int DEF_ORIGIN_L2 = 8;
    localparam int DEF_ORIGIN_L3 = 16;

    localparam int W_WAY      = 8;
    localparam int W_MASK     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int REC_SHIFT  = 16;
    localparam int SETTLE_CYCLES = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTE_LIMIT_L1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTE_LIMIT_L2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTE_LIMIT_L3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_L1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_L2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE_L2   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE_L3   = 3'd7;

    localparam logic [2:0] MODE_L1_L2 = 3'd2;
    localparam logic [2:0] MODE_L2_L3 = 3'd3;
    localparam logic [2:0] MODE_ALL   = 3'd4;

    localparam logic [2:0] MOVE_NONE     = 3'd0;
    localparam logic [2:0] MOVE_L1_TO_L2 = 3'd1;
    localparam logic [2:0] MOVE_L2_TO_L1 = 3'd2;
    localparam logic [2:0] MOVE_L2_TO_L3 = 3'd3;
    localparam logic [2:0] MOVE_L3_TO_L2 = 3'd4;

    localparam logic ACT_DECIDE   = 1'b0;
    localparam logic ACT_ROLLBACK = 1'b1;

    typedef logic signed [10:0] t_sval;

    typedef struct packed {
        logic              action;
        logic [W_MASK-1:0] miss_mask_l1;
        logic [W_MASK-1:0] miss_mask_l2;
        logic [W_MASK-1:0] miss_mask_l3;
    } t_item;

    typedef struct packed {
        logic             done_res;
        logic [2:0]       move_kind;
        logic [W_WAY-1:0] l1_end_way;
        logic [W_WAY-1:0] l2_start_way;
        logic [W_WAY-1:0] l2_end_way;
        logic [W_WAY-1:0] l3_end_way;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [W_WAY-1:0] l1_end;
        logic [W_WAY-1:0] l2_start;
        logic [W_WAY-1:0] l2_end;
        logic [W_WAY-1:0] l3_end;
    } t_ways;

    typedef struct packed {
        t_ways      ways;
        t_ways      saved;
        logic       saved_valid;
        logic [2:0] last_move;
    } t_state;

    typedef struct packed {
        logic [2:0]       shift_mode;
        logic [2:0]       vote_limit_l1;
        logic [2:0]       vote_limit_l2;
        logic [2:0]       vote_limit_l3;
        logic [3:0]       half_l1;
        logic [4:0]       step_l2;
        logic [3:0]       adaptive_l2;
        logic [4:0]       adaptive_l3;
        logic [W_WAY-1:0] max_l1;
        logic [W_WAY-1:0] max_l2;
        logic [W_WAY-1:0] max_l3;
    } t_limits;

    function automatic logic [2:0] popcount4(input logic [W_MASK-1:0] m);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < W_MASK; i++) begin
            n = n + 3'(m[i]);
        end
        return n;
    endfunction

    function automatic logic [W_WAY-1:0] cap8(input logic [10:0] v);
        return (v > 11'd255) ? 8'd255 : v[W_WAY-1:0];
    endfunction

endpackage

// ===== rtl/acws_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
interface acws_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/acws_cfg.sv =====
// Configuration registers and the registered way maxima derived from them.
module acws_cfg #(
    parameter int CORES     = acws_pkg::DEF_CORES,
    parameter int ORIGIN_L1 = acws_pkg::DEF_ORIGIN_L1,
    parameter int ORIGIN_L2 = acws_pkg::DEF_ORIGIN_L2,
    parameter int ORIGIN_L3 = acws_pkg::DEF_ORIGIN_L3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    acws_stream_if.sink       i_cfg,
    output acws_pkg::t_limits o_limits,
    output logic              o_settled
);
    import acws_pkg::*;

    localparam int unsigned REC_CORES = (2**REC_SHIFT + CORES - 1) / CORES;
    localparam int SETTLE_W = $clog2(SETTLE_CYCLES + 1);

    logic [2:0] r_shift_mode;
    logic [2:0] r_vote_limit_l1;
    logic [2:0] r_vote_limit_l2;
    logic [2:0] r_vote_limit_l3;
    logic [4:0] r_ratio_l1;
    logic [4:0] r_ratio_l2;
    logic [3:0] r_adaptive_l2;
    logic [4:0] r_adaptive_l3;
    logic [SETTLE_W-1:0] r_settle;

    logic [8:0]  r_prod_l1;
    logic [9:0]  r_prod_l2;
    logic [8:0]  r_num_l3;
    logic [16:0] r_rec_l3;
    logic        r_ratio2_zero;
    logic [4:0]  r_step_l2;
    logic [W_WAY-1:0] r_max_l1;
    logic [W_WAY-1:0] r_max_l2;
    logic [W_WAY-1:0] r_max_l3;

    logic        w_fire;
    logic [16:0] w_rec [32];
    logic [21:0] w_step_prod;
    logic [26:0] w_q_l2_prod;
    logic [25:0] w_q_l3_prod;
    logic [10:0] w_sum_l1;
    logic [10:0] w_sum_l2;
    logic [10:0] w_sum_l3;

    assign i_cfg.ready = 1'b1;
    assign w_fire      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_mode    <= 3'd0;
            r_vote_limit_l1 <= 3'd2;
            r_vote_limit_l2 <= 3'd2;
            r_vote_limit_l3 <= 3'd2;
            r_ratio_l1      <= 5'd2;
            r_ratio_l2      <= 5'd4;
            r_adaptive_l2   <= 4'd2;
            r_adaptive_l3   <= 5'd4;
        end else if (w_fire) begin
            unique case (i_cfg.payload.index)
                CFG_SHIFT_MODE:    r_shift_mode    <= i_cfg.payload.data[2:0];
                CFG_VOTE_LIMIT_L1: r_vote_limit_l1 <= i_cfg.payload.data[2:0];
                CFG_VOTE_LIMIT_L2: r_vote_limit_l2 <= i_cfg.payload.data[2:0];
                CFG_VOTE_LIMIT_L3: r_vote_limit_l3 <= i_cfg.payload.data[2:0];
                CFG_RATIO_L1:      r_ratio_l1      <= i_cfg.payload.data;
                CFG_RATIO_L2:      r_ratio_l2      <= i_cfg.payload.data;
                CFG_ADAPTIVE_L2:   r_adaptive_l2   <= i_cfg.payload.data[3:0];
                CFG_ADAPTIVE_L3:   r_adaptive_l3   <= i_cfg.payload.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_W'(SETTLE_CYCLES);
        end else if (w_fire) begin
            r_settle <= SETTLE_W'(SETTLE_CYCLES);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - SETTLE_W'(1);
        end
    end

    assign w_rec[0] = '0;
    for (genvar gi = 1; gi < 32; gi++) begin : g_rec
        localparam int unsigned REC = (2**REC_SHIFT + gi - 1) / gi;
        assign w_rec[gi] = 17'(REC);
    end

    assign w_step_prod = 22'(r_ratio_l2) * 22'(REC_CORES);

    always_ff @(posedge i_clk) begin
        r_prod_l1     <= 9'(r_adaptive_l2) * 9'(r_ratio_l1);
        r_prod_l2     <= 10'(r_adaptive_l3) * 10'(r_ratio_l2);
        r_num_l3      <= 9'(r_adaptive_l2) * 9'(CORES);
        r_rec_l3      <= w_rec[r_ratio_l2];
        r_ratio2_zero <= (r_ratio_l2 == 5'd0);
        r_step_l2     <= 5'(w_step_prod >> REC_SHIFT);
    end

    assign w_q_l2_prod = 27'(r_prod_l2) * 27'(REC_CORES);
    assign w_q_l3_prod = 26'(r_num_l3) * 26'(r_rec_l3);
    assign w_sum_l1 = 11'(ORIGIN_L1) + 11'(r_prod_l1 >> 1);
    assign w_sum_l2 = 11'(ORIGIN_L2) + 11'(w_q_l2_prod >> REC_SHIFT);
    assign w_sum_l3 = 11'(ORIGIN_L3) + 11'(w_q_l3_prod >> REC_SHIFT);

    always_ff @(posedge i_clk) begin
        r_max_l1 <= cap8(w_sum_l1);
        r_max_l2 <= cap8(w_sum_l2);
        r_max_l3 <= r_ratio2_zero ? W_WAY'(ORIGIN_L3) : cap8(w_sum_l3);
    end

    always_comb begin
        o_limits.shift_mode    = r_shift_mode;
        o_limits.vote_limit_l1 = r_vote_limit_l1;
        o_limits.vote_limit_l2 = r_vote_limit_l2;
        o_limits.vote_limit_l3 = r_vote_limit_l3;
        o_limits.half_l1       = r_ratio_l1[4:1];
        o_limits.step_l2       = r_step_l2;
        o_limits.adaptive_l2   = r_adaptive_l2;
        o_limits.adaptive_l3   = r_adaptive_l3;
        o_limits.max_l1        = r_max_l1;
        o_limits.max_l2        = r_max_l2;
        o_limits.max_l3        = r_max_l3;
    end

    assign o_settled = (r_settle == '0);

endmodule

// ===== rtl/acws_decide.sv =====
// Vote counting, move checks and move selection for one item.
module acws_decide #(
    parameter int CORES     = acws_pkg::DEF_CORES,
    parameter int ORIGIN_L1 = acws_pkg::DEF_ORIGIN_L1,
    parameter int ORIGIN_L2 = acws_pkg::DEF_ORIGIN_L2,
    parameter int ORIGIN_L3 = acws_pkg::DEF_ORIGIN_L3
) (
    input  acws_pkg::t_item   i_item,
    input  acws_pkg::t_state  i_state,
    input  acws_pkg::t_limits i_limits,
    output acws_pkg::t_state  o_next,
    output acws_pkg::t_result o_result
);
    import acws_pkg::*;

    localparam logic [W_MASK-1:0] CORE_MASK =
        (CORES >= 4) ? 4'hF : 4'((1 << CORES) - 1);
    localparam t_sval S_OL1 = t_sval'(ORIGIN_L1);
    localparam t_sval S_OL2 = t_sval'(ORIGIN_L2);
    localparam t_sval S_OL3 = t_sval'(ORIGIN_L3);

    t_ways p;
    t_sval s_p0, s_p1, s_p2, s_p3;
    t_sval s_half, s_step, s_a2, s_a3, s_max1, s_max2, s_max3;
    t_sval n_12, n_21, n_23e, n_23s, n_32s, n_32e;
    logic [2:0] v1, v2, v3, v12, v23;
    logic ok_12, ok_21, ok_23, ok_32;
    t_ways w_12, w_21, w_23, w_32, w_sel;
    logic [2:0] kind;

    assign p = i_state.ways;

    assign s_p0   = $signed({3'b000, p.l1_end});
    assign s_p1   = $signed({3'b000, p.l2_start});
    assign s_p2   = $signed({3'b000, p.l2_end});
    assign s_p3   = $signed({3'b000, p.l3_end});
    assign s_half = $signed({7'b0, i_limits.half_l1});
    assign s_step = $signed({6'b0, i_limits.step_l2});
    assign s_a2   = $signed({7'b0, i_limits.adaptive_l2});
    assign s_a3   = $signed({6'b0, i_limits.adaptive_l3});
    assign s_max1 = $signed({3'b000, i_limits.max_l1});
    assign s_max2 = $signed({3'b000, i_limits.max_l2});
    assign s_max3 = $signed({3'b000, i_limits.max_l3});

    assign v1  = popcount4(i_item.miss_mask_l1 & CORE_MASK);
    assign v2  = popcount4(i_item.miss_mask_l2 & CORE_MASK);
    assign v3  = popcount4(i_item.miss_mask_l3 & CORE_MASK);
    assign v12 = popcount4(i_item.miss_mask_l2 & ~i_item.miss_mask_l1 & CORE_MASK);
    assign v23 = popcount4(i_item.miss_mask_l3 & ~i_item.miss_mask_l2 & CORE_MASK);

    assign n_12  = s_p0 - s_half;
    assign n_21  = s_p0 + s_half;
    assign n_23e = s_p2 - s_step;
    assign n_23s = s_p1 + s_step;
    assign n_32s = s_p1 - s_step;
    assign n_32e = s_p2 + s_step;

    always_comb begin
        ok_12 = (s_p0 > S_OL1) && (s_p1 > 0) && (n_12 > S_OL1);
        w_12  = '{l1_end: W_WAY'(n_12), l2_start: W_WAY'(s_p1 - 1),
                  l2_end: p.l2_end, l3_end: p.l3_end};

        ok_21 = (s_p0 < s_max1) && (s_p1 < s_a2 - 1) && (n_21 < s_max1);
        w_21  = '{l1_end: W_WAY'(n_21), l2_start: W_WAY'(s_p1 + 1),
                  l2_end: p.l2_end, l3_end: p.l3_end};

        if (s_p2 > S_OL2) begin
            ok_23 = (n_23e >= S_OL2) && (s_p3 < S_OL3);
            w_23  = '{l1_end: p.l1_end, l2_start: p.l2_start,
                      l2_end: W_WAY'(n_23e), l3_end: W_WAY'(s_p3 + 1)};
        end else begin
            ok_23 = (s_p1 < s_a2 - 1) && (n_23s < s_a2) && (s_p3 < s_max3);
            w_23  = '{l1_end: p.l1_end, l2_start: W_WAY'(n_23s),
                      l2_end: p.l2_end, l3_end: W_WAY'(s_p3 + 1)};
        end

        if (s_p3 > S_OL3) begin
            ok_32 = (n_32s >= 0);
            w_32  = '{l1_end: p.l1_end, l2_start: W_WAY'(n_32s),
                      l2_end: p.l2_end, l3_end: W_WAY'(s_p3 - 1)};
        end else begin
            ok_32 = (s_p3 + s_a3 >= S_OL3) && (s_p3 > 0) && (n_32e < s_max2);
            w_32  = '{l1_end: p.l1_end, l2_start: p.l2_start,
                      l2_end: W_WAY'(n_32e), l3_end: W_WAY'(s_p3 - 1)};
        end
    end

    always_comb begin
        kind = MOVE_NONE;
        case (i_limits.shift_mode)
            MODE_L1_L2: begin
                if (v1 >= i_limits.vote_limit_l1) begin
                    if (ok_21) kind = MOVE_L2_TO_L1;
                end else if (v12 >= i_limits.vote_limit_l2) begin
                    if (ok_12) kind = MOVE_L1_TO_L2;
                end
            end
            MODE_L2_L3: begin
                if (v2 >= i_limits.vote_limit_l2) begin
                    if (ok_32) kind = MOVE_L3_TO_L2;
                end else if (v23 >= i_limits.vote_limit_l3) begin
                    if (ok_23) kind = MOVE_L2_TO_L3;
                end
            end
            MODE_ALL: begin
                if (v2 >= i_limits.vote_limit_l2) begin
                    if (ok_32) begin
                        kind = MOVE_L3_TO_L2;
                    end else if (v1 < i_limits.vote_limit_l1 && ok_12) begin
                        kind = MOVE_L1_TO_L2;
                    end
                end else if (v1 >= i_limits.vote_limit_l1) begin
                    if (ok_21) kind = MOVE_L2_TO_L1;
                end else if (v3 >= i_limits.vote_limit_l3) begin
                    if (ok_23) kind = MOVE_L2_TO_L3;
                end
            end
            default: kind = MOVE_NONE;
        endcase
    end

    always_comb begin
        case (kind)
            MOVE_L1_TO_L2: w_sel = w_12;
            MOVE_L2_TO_L1: w_sel = w_21;
            MOVE_L2_TO_L3: w_sel = w_23;
            MOVE_L3_TO_L2: w_sel = w_32;
            default:       w_sel = p;
        endcase
    end

    always_comb begin
        o_next             = i_state;
        o_result.done_res  = 1'b0;
        o_result.move_kind = MOVE_NONE;
        if (i_item.action == ACT_ROLLBACK) begin
            if (i_state.saved_valid) begin
                o_next.ways        = i_state.saved;
                o_next.saved_valid = 1'b0;
                o_result.done_res  = 1'b1;
                o_result.move_kind = i_state.last_move;
            end
        end else if (kind != MOVE_NONE) begin
            o_next.saved       = p;
            o_next.saved_valid = 1'b1;
            o_next.last_move   = kind;
            o_next.ways        = w_sel;
            o_result.done_res  = 1'b1;
            o_result.move_kind = kind;
        end
        o_result.l1_end_way   = o_next.ways.l1_end;
        o_result.l2_start_way = o_next.ways.l2_start;
        o_result.l2_end_way   = o_next.ways.l2_end;
        o_result.l3_end_way   = o_next.ways.l3_end;
    end

endmodule

// ===== rtl/acws_pipe.sv =====
// Input register, way state and result register with their flow control.
module acws_pipe #(
    parameter int ORIGIN_L1 = acws_pkg::DEF_ORIGIN_L1,
    parameter int ORIGIN_L2 = acws_pkg::DEF_ORIGIN_L2,
    parameter int ORIGIN_L3 = acws_pkg::DEF_ORIGIN_L3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    acws_stream_if.sink       i_in,
    acws_stream_if.source     o_res,
    input  logic              i_settled,
    input  acws_pkg::t_state  i_next,
    input  acws_pkg::t_result i_result,
    output acws_pkg::t_item   o_item,
    output acws_pkg::t_state  o_state
);
    import acws_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    logic    w_adv;
    logic    w_take;

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready  = i_settled && (!r_in_valid || w_adv);
    assign w_take      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_in.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.ways.l1_end   <= W_WAY'(ORIGIN_L1);
            r_state.ways.l2_start <= '0;
            r_state.ways.l2_end   <= W_WAY'(ORIGIN_L2);
            r_state.ways.l3_end   <= W_WAY'(ORIGIN_L3);
            r_state.saved         <= '0;
            r_state.saved_valid   <= 1'b0;
            r_state.last_move     <= MOVE_NONE;
        end else if (w_adv) begin
            r_state <= i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= i_result;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;
    assign o_item        = r_item;
    assign o_state       = r_state;

endmodule

// ===== rtl/adaptive_cache_way_shifter.sv =====
// Adaptive cache way shifter: top level.
//
// Channels: i_in takes items (decide or roll back with per-core miss masks),
// o_res returns one result item per input item, i_cfg writes the eight
// configuration registers by index and is always ready.
// Flow: an accepted item waits in the input register while the vote, check
// and selection logic works on it against the current way positions.
// Throughput: one item per cycle when not stalled or settling, set by the
// single pass between the input register and the result register; the way
// state updates at the same edge as the result register, so the next item
// sees it at once.
// Reset: way positions return to their origin counts with L2 start at zero,
// the saved snapshot clears, and i_in.ready stays low while the way maxima
// are derived from the reset register values.
// Configuration: after each write i_in.ready drops while the maxima pipeline
// recomputes.
// Stall: when o_res is held off, the result holds; one more item may wait in
// the input register, after which i_in.ready drops.
module adaptive_cache_way_shifter #(
    parameter int CORES     = acws_pkg::DEF_CORES,
    parameter int ORIGIN_L1 = acws_pkg::DEF_ORIGIN_L1,
    parameter int ORIGIN_L2 = acws_pkg::DEF_ORIGIN_L2,
    parameter int ORIGIN_L3 = acws_pkg::DEF_ORIGIN_L3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    acws_stream_if.sink   i_in,
    acws_stream_if.source o_res,
    acws_stream_if.sink   i_cfg
);
    import acws_pkg::*;

    t_limits w_limits;
    logic    w_settled;
    t_item   w_item;
    t_state  w_state;
    t_state  w_next;
    t_result w_result;

    acws_cfg #(
        .CORES     (CORES),
        .ORIGIN_L1 (ORIGIN_L1),
        .ORIGIN_L2 (ORIGIN_L2),
        .ORIGIN_L3 (ORIGIN_L3)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_limits  (w_limits),
        .o_settled (w_settled)
    );

    acws_decide #(
        .CORES     (CORES),
        .ORIGIN_L1 (ORIGIN_L1),
        .ORIGIN_L2 (ORIGIN_L2),
        .ORIGIN_L3 (ORIGIN_L3)
    ) u_decide (
        .i_item   (w_item),
        .i_state  (w_state),
        .i_limits (w_limits),
        .o_next   (w_next),
        .o_result (w_result)
    );

    acws_pipe #(
        .ORIGIN_L1 (ORIGIN_L1),
        .ORIGIN_L2 (ORIGIN_L2),
        .ORIGIN_L3 (ORIGIN_L3)
    ) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_res     (o_res),
        .i_settled (w_settled),
        .i_next    (w_next),
        .i_result  (w_result),
        .o_item    (w_item),
        .o_state   (w_state)
    );

endmodule

// ===== rtl/acws_checker.sv =====
// Port-level assertions for the adaptive cache way shifter, bound to the top level.
module acws_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input acws_pkg::t_result i_res
);
    import acws_pkg::*;

    a_idle_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res.done_res) |-> (i_res.move_kind == MOVE_NONE))
        else $error("result without a move carries a move kind");

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res.done_res) |->
            (i_res.move_kind == MOVE_L1_TO_L2 || i_res.move_kind == MOVE_L2_TO_L1 ||
             i_res.move_kind == MOVE_L2_TO_L3 || i_res.move_kind == MOVE_L3_TO_L2))
        else $error("completed move or rollback has no move kind");

    a_l2_start_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res.l2_start_way < 8'd16))
        else $error("L2 start position beyond adaptive range");

    a_reset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) == 1'b0) |-> !i_in_ready)
        else $error("item taken before the way maxima settled");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res)))
        else $error("stalled result item changed");

endmodule

bind adaptive_cache_way_shifter acws_checker u_acws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.payload)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the adaptive cache way shifter: directed and random items.
module tb;
    import acws_pkg::*;

    localparam int N_CORES = DEF_CORES;
    localparam int ORG_L1  = DEF_ORIGIN_L1;
    localparam int ORG_L2  = DEF_ORIGIN_L2;
    localparam int ORG_L3  = DEF_ORIGIN_L3;

    localparam int L1E = 0;
    localparam int L2S = 1;
    localparam int L2E = 2;
    localparam int L3E = 3;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_UNUSED = 3'd6;

    logic i_clk = 1'b0;
    logic i_rst_n;

    acws_stream_if #(.T_PAYLOAD(t_item))   in_if  ();
    acws_stream_if #(.T_PAYLOAD(t_result)) res_if ();
    acws_stream_if #(.T_PAYLOAD(t_cfg_wr)) cfg_if ();

    adaptive_cache_way_shifter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    t_item   pend_items[$];
    t_result due_results[$];
    bit      item_taken;
    bit      calm;
    int      miss_count;

    logic [2:0] cfg_mode;
    int         lim_v1, lim_v2, lim_v3;
    int         cfg_r1, cfg_r2, cfg_a2, cfg_a3;
    int         way_pos[4];
    int         snap_pos[4];
    bit         snap_ok;
    logic [2:0] last_kind;
    int         top_l1, top_l2, top_l3;

    function automatic void clear_model();
        cfg_mode  = MODE_IDLE;
        lim_v1    = 2;
        lim_v2    = 2;
        lim_v3    = 2;
        cfg_r1    = 2;
        cfg_r2    = 4;
        cfg_a2    = 2;
        cfg_a3    = 4;
        way_pos   = '{ORG_L1, 0, ORG_L2, ORG_L3};
        snap_pos  = '{0, 0, 0, 0};
        snap_ok   = 1'b0;
        last_kind = MOVE_NONE;
    endfunction

    function automatic void take_reg(t_cfg_wr w);
        case (w.index)
            CFG_SHIFT_MODE:    cfg_mode = w.data[2:0];
            CFG_VOTE_LIMIT_L1: lim_v1 = int'(w.data[2:0]);
            CFG_VOTE_LIMIT_L2: lim_v2 = int'(w.data[2:0]);
            CFG_VOTE_LIMIT_L3: lim_v3 = int'(w.data[2:0]);
            CFG_RATIO_L1:      cfg_r1 = int'(w.data);
            CFG_RATIO_L2:      cfg_r2 = int'(w.data);
            CFG_ADAPTIVE_L2:   cfg_a2 = int'(w.data[3:0]);
            CFG_ADAPTIVE_L3:   cfg_a3 = int'(w.data);
            default: ;
        endcase
    endfunction

    function automatic int ones(logic [3:0] m);
        int n;
        n = 0;
        for (int i = 0; i < N_CORES && i < 4; i++) begin
            n += m[i];
        end
        return n;
    endfunction

    function automatic int clip255(int v);
        return (v > 255) ? 255 : v;
    endfunction

    function automatic bit commit_move(logic [2:0] kind, int l1e, int l2s, int l2e, int l3e);
        snap_pos  = way_pos;
        snap_ok   = 1'b1;
        last_kind = kind;
        way_pos   = '{l1e, l2s, l2e, l3e};
        return 1'b1;
    endfunction

    function automatic bit shrink_l1();
        int np;
        if (!(way_pos[L1E] > ORG_L1 && way_pos[L2S] > 0)) return 1'b0;
        np = way_pos[L1E] - cfg_r1 / 2;
        if (np <= ORG_L1) return 1'b0;
        return commit_move(MOVE_L1_TO_L2, np, way_pos[L2S] - 1, way_pos[L2E], way_pos[L3E]);
    endfunction

    function automatic bit grow_l1();
        int np;
        if (!(way_pos[L1E] < top_l1 && way_pos[L2S] < cfg_a2 - 1)) return 1'b0;
        np = way_pos[L1E] + cfg_r1 / 2;
        if (np >= top_l1) return 1'b0;
        return commit_move(MOVE_L2_TO_L1, np, way_pos[L2S] + 1, way_pos[L2E], way_pos[L3E]);
    endfunction

    function automatic bit grow_l3();
        int step;
        int np;
        step = cfg_r2 / N_CORES;
        if (way_pos[L2E] > ORG_L2) begin
            np = way_pos[L2E] - step;
            if (np >= ORG_L2 && way_pos[L3E] < ORG_L3) begin
                return commit_move(MOVE_L2_TO_L3, way_pos[L1E], way_pos[L2S], np,
                                   way_pos[L3E] + 1);
            end
            return 1'b0;
        end
        if (way_pos[L2S] < cfg_a2 - 1) begin
            np = way_pos[L2S] + step;
            if (np < cfg_a2 && way_pos[L3E] < top_l3) begin
                return commit_move(MOVE_L2_TO_L3, way_pos[L1E], np, way_pos[L2E],
                                   way_pos[L3E] + 1);
            end
        end
        return 1'b0;
    endfunction

    function automatic bit grow_l2();
        int step;
        int np;
        step = cfg_r2 / N_CORES;
        if (way_pos[L3E] > ORG_L3) begin
            np = way_pos[L2S] - step;
            if (np >= 0) begin
                return commit_move(MOVE_L3_TO_L2, way_pos[L1E], np, way_pos[L2E],
                                   way_pos[L3E] - 1);
            end
            return 1'b0;
        end
        if (way_pos[L3E] >= ORG_L3 - cfg_a3 && way_pos[L3E] > 0) begin
            np = way_pos[L2E] + step;
            if (np < top_l2) begin
                return commit_move(MOVE_L3_TO_L2, way_pos[L1E], way_pos[L2S], np,
                                   way_pos[L3E] - 1);
            end
        end
        return 1'b0;
    endfunction

    function automatic bit pick_move(logic [3:0] m1, logic [3:0] m2, logic [3:0] m3);
        int v1;
        int v2;
        int v3;
        v1 = ones(m1);
        v2 = ones(m2);
        v3 = ones(m3);
        top_l1 = clip255(ORG_L1 + cfg_a2 * cfg_r1 / 2);
        top_l2 = clip255(ORG_L2 + cfg_a3 * cfg_r2 / N_CORES);
        top_l3 = (cfg_r2 == 0) ? ORG_L3 : clip255(ORG_L3 + cfg_a2 * N_CORES / cfg_r2);
        case (cfg_mode)
            MODE_L1_L2: begin
                if (v1 >= lim_v1) return grow_l1();
                if (ones(m2 & ~m1) >= lim_v2) return shrink_l1();
                return 1'b0;
            end
            MODE_L2_L3: begin
                if (v2 >= lim_v2) return grow_l2();
                if (ones(m3 & ~m2) >= lim_v3) return grow_l3();
                return 1'b0;
            end
            MODE_ALL: begin
                if (v2 >= lim_v2) begin
                    if (grow_l2()) return 1'b1;
                    if (v1 < lim_v1) return shrink_l1();
                    return 1'b0;
                end
                if (v1 >= lim_v1) return grow_l1();
                if (v3 >= lim_v3) return grow_l3();
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_result shift_ways(t_item it);
        t_result r;
        r.done_res  = 1'b0;
        r.move_kind = MOVE_NONE;
        if (it.action == ACT_ROLLBACK) begin
            if (snap_ok) begin
                way_pos     = snap_pos;
                snap_ok     = 1'b0;
                r.done_res  = 1'b1;
                r.move_kind = last_kind;
            end
        end else if (pick_move(it.miss_mask_l1, it.miss_mask_l2, it.miss_mask_l3)) begin
            r.done_res  = 1'b1;
            r.move_kind = last_kind;
        end
        r.l1_end_way   = 8'(way_pos[L1E]);
        r.l2_start_way = 8'(way_pos[L2S]);
        r.l2_end_way   = 8'(way_pos[L2E]);
        r.l3_end_way   = 8'(way_pos[L3E]);
        return r;
    endfunction

    function automatic void put(logic act, logic [3:0] m1, logic [3:0] m2, logic [3:0] m3);
        t_item it;
        it.action       = act;
        it.miss_mask_l1 = m1;
        it.miss_mask_l2 = m2;
        it.miss_mask_l3 = m3;
        pend_items.push_back(it);
    endfunction

    function automatic t_item pick_item(int pat);
        t_item it;
        it.action       = ($urandom_range(99) < 12) ? ACT_ROLLBACK : ACT_DECIDE;
        it.miss_mask_l1 = 4'($urandom);
        it.miss_mask_l2 = 4'($urandom);
        it.miss_mask_l3 = 4'($urandom);
        if ($urandom_range(99) >= 10) begin
            case (pat)
                0: it.miss_mask_l1 = 4'hF;
                1: begin
                    it.miss_mask_l1 = 4'h0;
                    it.miss_mask_l2 = 4'hF;
                end
                2: begin
                    it.miss_mask_l1 = 4'h0;
                    it.miss_mask_l2 = 4'h0;
                    it.miss_mask_l3 = 4'hF;
                end
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic settle();
        while (pend_items.size() != 0 || due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_cfg_wr w;
        w.index = idx;
        w.data  = val;
        @(negedge i_clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= w;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_all(logic [4:0] mode, logic [4:0] v1, logic [4:0] v2,
                             logic [4:0] v3, logic [4:0] r1, logic [4:0] r2,
                             logic [4:0] a2, logic [4:0] a3);
        write_reg(CFG_SHIFT_MODE, mode);
        write_reg(CFG_VOTE_LIMIT_L1, v1);
        write_reg(CFG_VOTE_LIMIT_L2, v2);
        write_reg(CFG_VOTE_LIMIT_L3, v3);
        write_reg(CFG_RATIO_L1, r1);
        write_reg(CFG_RATIO_L2, r2);
        write_reg(CFG_ADAPTIVE_L2, a2);
        write_reg(CFG_ADAPTIVE_L3, a3);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !item_taken) begin
            // hold the item until it is taken
        end else if (pend_items.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
            in_if.valid   <= 1'b1;
            in_if.payload <= pend_items[0];
        end else begin
            in_if.valid <= 1'b0;
        end
        res_if.ready <= calm || ($urandom_range(99) >= 38);
    end

    always @(posedge i_clk) begin : monitor
        t_result due;
        t_result got;
        if (!i_rst_n) begin
            item_taken = 1'b0;
            clear_model();
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.payload;
                if (due_results.size() == 0) begin
                    miss_count++;
                    if (miss_count <= 10) begin
                        $display("unexpected result: done=%0d kind=%0d ways=%0d/%0d/%0d/%0d",
                                 got.done_res, got.move_kind, got.l1_end_way,
                                 got.l2_start_way, got.l2_end_way, got.l3_end_way);
                    end
                end else begin
                    due = due_results.pop_front();
                    if (got.done_res !== due.done_res || got.move_kind !== due.move_kind ||
                        got.l1_end_way !== due.l1_end_way ||
                        got.l2_start_way !== due.l2_start_way ||
                        got.l2_end_way !== due.l2_end_way ||
                        got.l3_end_way !== due.l3_end_way) begin
                        miss_count++;
                        if (miss_count <= 10) begin
                            $display("mismatch: exp done=%0d kind=%0d ways=%0d/%0d/%0d/%0d",
                                     due.done_res, due.move_kind, due.l1_end_way,
                                     due.l2_start_way, due.l2_end_way, due.l3_end_way);
                            $display("          got done=%0d kind=%0d ways=%0d/%0d/%0d/%0d",
                                     got.done_res, got.move_kind, got.l1_end_way,
                                     got.l2_start_way, got.l2_end_way, got.l3_end_way);
                        end
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                take_reg(cfg_if.payload);
            end
            item_taken = in_if.valid && in_if.ready;
            if (item_taken) begin
                due_results.push_back(shift_ways(in_if.payload));
                pend_items.delete(0);
            end
        end
    end

    initial begin
        #3000000;
        $display("** adaptive_cache_way_shifter: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int burst;
        int pat;
        i_rst_n        = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        calm           = 1'b0;
        burst          = 0;
        pat            = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        put(ACT_DECIDE, 4'hF, 4'hF, 4'hF);
        put(ACT_ROLLBACK, 4'h0, 4'h0, 4'h0);
        settle();
        write_all(5'(MODE_L1_L2), 5'd2, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8, 5'd4);
        put(ACT_DECIDE, 4'hF, 4'h0, 4'h0);
        put(ACT_DECIDE, 4'h3, 4'h0, 4'h0);
        put(ACT_ROLLBACK, 4'hF, 4'hF, 4'hF);
        put(ACT_ROLLBACK, 4'h0, 4'h0, 4'h0);
        put(ACT_DECIDE, 4'h0, 4'hF, 4'h0);
        put(ACT_DECIDE, 4'h1, 4'h2, 4'h0);
        settle();
        write_reg(CFG_SHIFT_MODE, 5'(MODE_L2_L3));
        put(ACT_DECIDE, 4'h0, 4'hF, 4'h0);
        put(ACT_DECIDE, 4'h0, 4'h0, 4'hF);
        put(ACT_DECIDE, 4'h0, 4'h0, 4'hC);
        put(ACT_DECIDE, 4'h0, 4'hF, 4'h0);
        settle();
        write_reg(CFG_SHIFT_MODE, 5'(MODE_ALL));
        put(ACT_DECIDE, 4'hF, 4'hF, 4'h0);
        put(ACT_DECIDE, 4'h0, 4'h0, 4'hF);
        put(ACT_DECIDE, 4'hF, 4'h0, 4'h0);
        put(ACT_DECIDE, 4'h0, 4'hF, 4'hF);
        settle();
        write_reg(CFG_SHIFT_MODE, 5'(MODE_UNUSED));
        put(ACT_DECIDE, 4'hF, 4'hF, 4'hF);
        settle();
        write_reg(CFG_SHIFT_MODE, 5'(MODE_L1_L2));
        write_reg(CFG_VOTE_LIMIT_L1, 5'd0);
        put(ACT_DECIDE, 4'h0, 4'h0, 4'h0);
        settle();
        write_reg(CFG_SHIFT_MODE, 5'(MODE_L2_L3));
        write_reg(CFG_RATIO_L2, 5'd0);
        put(ACT_DECIDE, 4'h0, 4'h0, 4'hF);
        put(ACT_DECIDE, 4'h0, 4'hF, 4'h0);

        for (int ph = 0; ph < 12; ph++) begin
            settle();
            calm = (ph == 5);
            case (ph)
                0: write_all(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
                1: write_all(5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31);
                2: write_all(5'(MODE_ALL), 5'd0, 5'd0, 5'd0, 5'd31, 5'd31, 5'd15, 5'd31);
                3: write_all(5'(MODE_L2_L3), 5'd2, 5'd2, 5'd2, 5'd2, 5'd1, 5'd8, 5'd16);
                4: write_all(5'(MODE_ALL), 5'd1, 5'd1, 5'd1, 5'd4, 5'd0, 5'd8, 5'd8);
                default: begin
                    write_all(5'(($urandom_range(99) < 85) ? $urandom_range(4, 2)
                                                           : $urandom_range(7, 0)),
                              5'($urandom_range(4, 0)), 5'($urandom_range(4, 0)),
                              5'($urandom_range(4, 0)), 5'($urandom_range(16, 0)),
                              5'($urandom_range(16, 0)), 5'($urandom_range(8, 0)),
                              5'($urandom_range(16, 0)));
                end
            endcase
            for (int n = 0; n < 140; n++) begin
                if (burst == 0) begin
                    pat   = $urandom_range(3);
                    burst = $urandom_range(24, 1);
                end
                burst--;
                pend_items.push_back(pick_item(pat));
            end
        end

        settle();
        repeat (SETTLE_CYCLES + 10) @(posedge i_clk);
        if (miss_count == 0 && due_results.size() == 0) begin
            $display("** adaptive_cache_way_shifter: PASSED **");
        end else begin
            $display("** adaptive_cache_way_shifter: FAILED **");
        end
        $finish;
    end
endmodule
